/* design/b32d_pkg.sv */
// shared types, constants and helpers for the prefixed base32 identifier decoder
// no dependencies

package b32d_pkg;

    localparam int MAX_ID_BYTES     = 32;
    localparam int MAX_PREFIX_CHARS = 8;

    localparam int CHAR_W   = 8;
    localparam int PREFIX_W = CHAR_W * MAX_PREFIX_CHARS;
    localparam int PLEN_W   = 4;
    localparam int NBYTES_W = 6;
    localparam int PIDX_W   = $clog2(MAX_PREFIX_CHARS);
    localparam int CNT_W    = 8;
    localparam int BUF_W    = 7;
    localparam int NBITS_W  = 3;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BYTE_COUNT = 2'd2;

    localparam logic [NBYTES_W-1:0] ID_BYTES_RESET = 6'd16;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PREFIX   = 3'd1,
        ST_LENGTH   = 3'd2,
        ST_CHAR     = 3'd3,
        ST_NONCANON = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SYM_VALID,
        SYM_UPPER,
        SYM_BAD
    } t_sym_kind;

    typedef struct packed {
        t_sym_kind  kind;
        logic [4:0] value;
    } t_sym;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char;

    typedef struct packed {
        logic [PREFIX_W-1:0] prefix_chars;
        logic [PLEN_W-1:0]   prefix_length;
        logic [NBYTES_W-1:0] id_byte_count;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic        done;
        logic        byte_valid;
        logic [7:0]  data;
    } t_result;

    // lowercase rfc 4648 alphabet, upper-case letters flagged apart
    function automatic t_sym sym_decode(input logic [CHAR_W-1:0] c);
        t_sym s;
        s.kind  = SYM_BAD;
        s.value = 5'd0;
        if (c >= "a" && c <= "z") begin
            s.kind  = SYM_VALID;
            s.value = 5'(c - "a");
        end else if (c >= "2" && c <= "7") begin
            s.kind  = SYM_VALID;
            s.value = 5'(c - "2" + 8'd26);
        end else if (c >= "A" && c <= "Z") begin
            s.kind  = SYM_UPPER;
        end
        return s;
    endfunction

endpackage

/* design/prefixed_base32_identifier_decoder_core.sv */
// top level of the prefixed base32 identifier decoder: config registers,
// input stage, decode step and result register; depends on b32d_pkg,
// b32d_in_stage and b32d_decode
//
// usage
//   input stream: one text character per transaction on i_s_tdata, i_s_tlast
//   high on the final character. output stream: a transaction whenever a byte
//   completes (o_m_tuser[0] set) and one on the final character (o_m_tlast
//   set, o_m_tuser[3:1] the status: 0 ok, 1 bad prefix, 2 bad length,
//   3 bad character, 4 non-canonical). bytes of a text count only if its
//   status is ok. characters that produce nothing give no output transaction.
//   each character is held in the input register, then passes through the
//   decode logic into the result register. throughput is one character per
//   cycle while the receiver does not stall; the loop that sets it is the
//   per-text state update. when the receiver stalls the result register holds,
//   the input register holds the next character and o_s_tready drops until
//   the result is taken. reset clears both stages and all per-text state, and
//   loads the registers with prefix empty and 16 identifier bytes. the user
//   makes configuration writes through i_cfg_we / i_cfg_index / i_cfg_data
//   only while the block is idle; the block itself does not enforce it.

module prefixed_base32_identifier_decoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // [7:0] char_code
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [7:0]                          o_m_tdata,   // [7:0] data_byte
    output logic [3:0]                          o_m_tuser,   // [0] byte_valid, [3:1] status
    output logic                                o_m_tlast,
    input  logic                                i_cfg_we,
    input  logic [b32d_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [b32d_pkg::PREFIX_W-1:0]       i_cfg_data
);
    import b32d_pkg::*;

    t_cfg    r_cfg;
    t_char   in_char;
    t_char   stage_char;
    logic    stage_valid;
    logic    advance;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefix_chars  <= '0;
            r_cfg.prefix_length <= '0;
            r_cfg.id_byte_count <= ID_BYTES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PREFIX_CHARS:  r_cfg.prefix_chars  <= i_cfg_data;
                CFG_PREFIX_LENGTH: r_cfg.prefix_length <= i_cfg_data[PLEN_W-1:0];
                CFG_ID_BYTE_COUNT: r_cfg.id_byte_count <= i_cfg_data[NBYTES_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_char.code = i_s_tdata;
    assign in_char.last = i_s_tlast;

    assign advance = stage_valid && (!r_out_valid || i_m_tready);

    b32d_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_char    (in_char),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_char    (stage_char)
    );

    b32d_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_char      (stage_char),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.data;
    assign o_m_tuser  = {r_out.status, r_out.byte_valid};
    assign o_m_tlast  = r_out.done;

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[3:1] != ST_OK |-> o_m_tlast)
        else $error("status given on a non-final transaction");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |-> !advance)
        else $error("result register overwritten while stalled");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser[0] || o_m_tlast)
        else $error("output transaction with neither byte nor final status");

endmodule

/* design/b32d_in_stage.sv */
// input register stage of the base32 identifier decoder
// depends on b32d_pkg

module b32d_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  b32d_pkg::t_char i_char,
    input  logic            i_advance,
    output logic            o_valid,
    output b32d_pkg::t_char o_char
);
    import b32d_pkg::*;

    logic  r_valid;
    t_char r_char;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_char  = r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char;
        end
    end

endmodule

/* design/b32d_decode.sv */
// per-text state and one-character decode step: prefix check, 5-bit symbol
// gathering, byte emission and final status; depends on b32d_pkg

module b32d_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  b32d_pkg::t_char   i_char,
    input  b32d_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output b32d_pkg::t_result o_res
);
    import b32d_pkg::*;

    logic [CNT_W-1:0]    r_char_counter, n_char_counter;
    logic [BUF_W-1:0]    r_bit_buffer, n_bit_buffer;
    logic [NBITS_W-1:0]  r_buffered_bits, n_buffered_bits;
    logic [NBYTES_W-1:0] r_bytes_out, n_bytes_out;
    logic                r_prefix_mismatch, n_prefix_mismatch;
    t_status             r_first_err, n_first_err;

    logic [PLEN_W-1:0]   plen;
    logic [NBYTES_W-1:0] nbytes;
    logic [8:0]          len_x;
    logic [16:0]         len_prod;
    logic [CNT_W-1:0]    expected;
    logic [CHAR_W-1:0]   want;
    t_sym                sym;
    logic [11:0]         acc;
    logic [11:0]         acc_sh;
    logic [3:0]          bits;
    logic                emit;
    logic [7:0]          data;
    t_status             st;

    always_comb begin
        plen = (i_cfg.prefix_length > PLEN_W'(MAX_PREFIX_CHARS))
             ? PLEN_W'(MAX_PREFIX_CHARS) : i_cfg.prefix_length;
        if (i_cfg.id_byte_count == '0) begin
            nbytes = NBYTES_W'(1);
        end else if (i_cfg.id_byte_count > NBYTES_W'(MAX_ID_BYTES)) begin
            nbytes = NBYTES_W'(MAX_ID_BYTES);
        end else begin
            nbytes = i_cfg.id_byte_count;
        end
        // ceil(8n/5) as (8n+4)*205 >> 10, exact for this range
        len_x    = {nbytes, 3'b000} + 9'd4;
        len_prod = 17'(len_x) * 17'd205;
        expected = CNT_W'(plen) + CNT_W'(len_prod[16:10]);
    end

    always_comb begin
        n_char_counter    = r_char_counter;
        n_bit_buffer      = r_bit_buffer;
        n_buffered_bits   = r_buffered_bits;
        n_bytes_out       = r_bytes_out;
        n_prefix_mismatch = r_prefix_mismatch;
        n_first_err       = r_first_err;
        emit   = 1'b0;
        data   = 8'd0;
        want   = i_cfg.prefix_chars[CHAR_W*r_char_counter[PIDX_W-1:0] +: CHAR_W];
        sym    = sym_decode(i_char.code);
        acc    = {r_bit_buffer, sym.value};
        bits   = 4'(r_buffered_bits) + 4'd5;
        acc_sh = '0;
        st     = ST_OK;

        if (r_char_counter != {CNT_W{1'b1}}) begin
            n_char_counter = r_char_counter + 1'b1;
        end

        if (r_char_counter < CNT_W'(plen)) begin
            if (i_char.code != want) begin
                n_prefix_mismatch = 1'b1;
            end
        end else if (r_first_err == ST_OK) begin
            case (sym.kind)
                SYM_UPPER: n_first_err = ST_NONCANON;
                SYM_BAD:   n_first_err = ST_CHAR;
                default: begin
                    if (bits >= 4'd8) begin
                        bits = bits - 4'd8;
                        if (r_bytes_out < nbytes) begin
                            acc_sh      = acc >> bits;
                            data        = acc_sh[7:0];
                            emit        = 1'b1;
                            n_bytes_out = r_bytes_out + 1'b1;
                        end
                    end
                    n_bit_buffer    = BUF_W'(acc & ((12'd1 << bits) - 12'd1));
                    n_buffered_bits = bits[NBITS_W-1:0];
                end
            endcase
        end

        if (n_prefix_mismatch || n_char_counter < CNT_W'(plen)) begin
            st = ST_PREFIX;
        end else if (n_char_counter != expected) begin
            st = ST_LENGTH;
        end else if (n_first_err != ST_OK) begin
            st = n_first_err;
        end else if (n_buffered_bits != '0 && n_bit_buffer != '0) begin
            st = ST_NONCANON;
        end
    end

    assign o_res_valid     = emit || i_char.last;
    assign o_res.data       = data;
    assign o_res.byte_valid = emit;
    assign o_res.done       = i_char.last;
    assign o_res.status     = i_char.last ? st : ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_counter    <= '0;
            r_bit_buffer      <= '0;
            r_buffered_bits   <= '0;
            r_bytes_out       <= '0;
            r_prefix_mismatch <= 1'b0;
            r_first_err       <= ST_OK;
        end else if (i_fire) begin
            if (i_char.last) begin
                // text finished, back to a clean slate
                r_char_counter    <= '0;
                r_bit_buffer      <= '0;
                r_buffered_bits   <= '0;
                r_bytes_out       <= '0;
                r_prefix_mismatch <= 1'b0;
                r_first_err       <= ST_OK;
            end else begin
                r_char_counter    <= n_char_counter;
                r_bit_buffer      <= n_bit_buffer;
                r_buffered_bits   <= n_buffered_bits;
                r_bytes_out       <= n_bytes_out;
                r_prefix_mismatch <= n_prefix_mismatch;
                r_first_err       <= n_first_err;
            end
        end
    end

    a_bytes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_out <= NBYTES_W'(MAX_ID_BYTES))
        else $error("bytes_out beyond the identifier size");

    a_buffer_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_buffer >> r_buffered_bits) == '0)
        else $error("leftover bits wider than their count");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_char.last |=> r_char_counter == '0 && r_bytes_out == '0)
        else $error("text state not cleared after final character");

endmodule

/* tb/tb.sv */
// self-checking testbench for prefixed_base32_identifier_decoder_core
// drives text characters on the input stream, predicts bytes and final status in a
// scoreboard class and checks every output transaction; depends on b32d_pkg and the core

module tb;
    import b32d_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum {
        TK_GOOD, TK_NONCANON, TK_BAD_PREFIX, TK_SHORT, TK_LONG,
        TK_UPPER, TK_BADCHAR, TK_CUT_PREFIX, TK_NOISE, TK_HUGE
    } t_text_kind;

    // tracks one text at a time and holds the decoded output still owed by the core
    class t_id_text_tracker;
        logic [PREFIX_W-1:0] prefix_chars;
        logic [PLEN_W-1:0]   prefix_len;
        logic [NBYTES_W-1:0] id_bytes;
        logic [CNT_W-1:0]    chars_seen;
        logic [BUF_W-1:0]    spare_bits;
        int                  spare_count;
        int                  bytes_done;
        bit                  prefix_bad;
        t_status             char_fault;
        t_result             expected_out[$];
        int                  mismatches;
        int                  results_checked;
        int                  bytes_checked;
        int                  status_seen[5];

        function new();
            prefix_chars = '0;
            prefix_len = '0;
            id_bytes = ID_BYTES_RESET;
            mismatches = 0;
            results_checked = 0;
            bytes_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_text();
        endfunction

        function void clear_text();
            chars_seen = '0;
            spare_bits = '0;
            spare_count = 0;
            bytes_done = 0;
            prefix_bad = 1'b0;
            char_fault = ST_OK;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PREFIX_W-1:0] data);
            case (idx)
                CFG_PREFIX_CHARS:  prefix_chars = data;
                CFG_PREFIX_LENGTH: prefix_len = data[PLEN_W-1:0];
                CFG_ID_BYTE_COUNT: id_bytes = data[NBYTES_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_char(logic [7:0] c, logic last);
            int      plen;
            int      nbytes;
            int      pos;
            int      sym;
            int      acc;
            int      nbits;
            bit      emit;
            t_result r;
            plen = (prefix_len > MAX_PREFIX_CHARS) ? MAX_PREFIX_CHARS : int'(prefix_len);
            nbytes = (id_bytes < 1) ? 1 : (id_bytes > MAX_ID_BYTES) ? MAX_ID_BYTES
                                                                     : int'(id_bytes);
            pos = int'(chars_seen);
            emit = 1'b0;
            r = '0;
            if (chars_seen != 8'hff) chars_seen++;
            if (pos < plen) begin
                if (c != prefix_chars[8*pos +: 8]) prefix_bad = 1'b1;
            end else if (char_fault == ST_OK) begin
                if (c >= "a" && c <= "z") sym = int'(c) - int'("a");
                else if (c >= "2" && c <= "7") sym = int'(c) - int'("2") + 26;
                else if (c >= "A" && c <= "Z") sym = -1;
                else sym = -2;
                // first bad character freezes decoding for the rest of the text
                if (sym == -1) begin
                    char_fault = ST_NONCANON;
                end else if (sym == -2) begin
                    char_fault = ST_CHAR;
                end else begin
                    acc = (int'(spare_bits) << 5) | sym;
                    nbits = spare_count + 5;
                    if (nbits >= 8) begin
                        nbits -= 8;
                        if (bytes_done < nbytes) begin
                            r.data = 8'(acc >> nbits);
                            r.byte_valid = 1'b1;
                            emit = 1'b1;
                            bytes_done++;
                        end
                    end
                    spare_bits = BUF_W'(acc & ((1 << nbits) - 1));
                    spare_count = nbits;
                end
            end
            if (emit || last) begin
                r.done = last;
                r.status = ST_OK;
                if (last) begin
                    if (prefix_bad || int'(chars_seen) < plen)
                        r.status = ST_PREFIX;
                    else if (int'(chars_seen) != plen + (nbytes * 8 + 4) / 5)
                        r.status = ST_LENGTH;
                    else if (char_fault != ST_OK)
                        r.status = char_fault;
                    else if (spare_count != 0 && spare_bits != 0)
                        r.status = ST_NONCANON;
                    clear_text();
                end
                expected_out.insert(expected_out.size(), r);
            end
        endfunction

        function void check_output(logic [7:0] data, logic [3:0] user, logic last);
            t_result want;
            if (expected_out.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected output: data %02h user %h last %0b",
                             $realtime, data, user, last);
                return;
            end
            want = expected_out.pop_front();
            results_checked++;
            if (data !== want.data || user[0] !== want.byte_valid ||
                last !== want.done || user[3:1] !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch: expected data %02h valid %0b last %0b status %0d,",
                              " got data %02h valid %0b last %0b status %0d"},
                             $realtime, want.data, want.byte_valid, want.done, want.status,
                             data, user[0], last, user[3:1]);
            end else begin
                if (want.byte_valid) bytes_checked++;
                if (want.done) status_seen[want.status]++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata = '0;       // [7:0] char_code
    logic                 i_s_tlast = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [7:0]           o_m_tdata;            // [7:0] data_byte
    logic [3:0]           o_m_tuser;            // [0] byte_valid, [3:1] status
    logic                 o_m_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PREFIX_W-1:0]  i_cfg_data = '0;

    prefixed_base32_identifier_decoder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_id_text_tracker tracker = new();

    logic [7:0]          text_q[$];
    logic [PREFIX_W-1:0] cur_prefix = '0;
    int                  eff_plen = 0;
    int                  eff_nbytes = 16;
    int                  burst_texts = 0;
    int                  hold_cycles = 0;
    bit                  rx_eager = 1'b0;
    int                  chars_sent = 0;
    int                  texts_sent = 0;
    int                  settings_used = 1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] sym_char(int v);
        return (v < 26) ? 8'("a" + v) : 8'("2" + v - 26);
    endfunction

    // sends the queued text, one character per transaction, last flag on the final one
    task automatic send_text();
        int gap;
        bit no_gaps;
        no_gaps = (burst_texts > 0) || ($urandom_range(0, 3) == 0);
        if (burst_texts > 0) burst_texts--;
        for (int i = 0; i < text_q.size(); i++) begin
            gap = no_gaps ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata <= text_q[i];
            i_s_tlast <= (i == text_q.size() - 1);
            @(posedge i_clk);
            while (o_s_tready !== 1'b1) @(posedge i_clk);
            tracker.take_char(text_q[i], i == text_q.size() - 1);
        end
        chars_sent += text_q.size();
        texts_sent++;
        text_q.delete();
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++) text_q.insert(text_q.size(), s[i]);
        send_text();
    endtask

    // the core holds no result when it goes quiet, let the pipeline settle anyway
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (tracker.expected_out.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PREFIX_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    initial begin : receiver
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = rx_eager ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (o_m_tvalid !== 1'b1) @(posedge i_clk);
            tracker.check_output(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    initial begin : watchdog
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int                  phase;
        int                  phase_chars;
        int                  random_chars;
        int                  pl;
        int                  nb;
        int                  blen;
        int                  lo;
        int                  mask;
        int                  v;
        int                  pos;
        int                  k;
        int                  r;
        logic [7:0]          c;
        logic [PREFIX_W-1:0] wdata;
        t_text_kind          kind;
        logic [7:0]          near_miss[8];

        near_miss = '{8'h60, "{", "1", "8", "@", "[", 8'h00, 8'hff};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty prefix, 16 bytes, so a single char is a length error
        send_string("7");
        wait_idle();

        // prefix "x_", one byte identifier
        write_reg(CFG_PREFIX_CHARS, {$urandom, 16'($urandom), "_", "x"});
        write_reg(CFG_PREFIX_LENGTH, PREFIX_W'(2));
        write_reg(CFG_ID_BYTE_COUNT, PREFIX_W'(1));
        write_reg(CFG_SPARE, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        settings_used++;
        send_string("x_74");   // all ones byte
        send_string("x_aa");   // all zeros byte
        send_string("x_ab");   // nonzero leftover bits
        send_string("x_aA");   // upper-case letter
        send_string("x_a{");   // invalid character
        send_string("y_aa");   // prefix mismatch
        send_string("x");      // text shorter than prefix
        wait_idle();

        random_chars = 0;
        for (phase = 0; random_chars < 1750; phase++) begin
            case (phase % 6)
                0: begin pl = 8; nb = 32; end
                1: begin pl = 0; nb = 1; end
                2: begin pl = $urandom_range(9, 15); nb = $urandom_range(33, 63); end
                3: begin pl = $urandom_range(0, 8); nb = 0; end
                default: begin pl = $urandom_range(0, 8); nb = $urandom_range(1, 8); end
            endcase
            if (phase == 1) cur_prefix = '0;
            else if (phase == 2) cur_prefix = '1;
            else cur_prefix = {$urandom, $urandom};
            eff_plen = (pl > MAX_PREFIX_CHARS) ? MAX_PREFIX_CHARS : pl;
            eff_nbytes = (nb < 1) ? 1 : (nb > MAX_ID_BYTES) ? MAX_ID_BYTES : nb;

            write_reg(CFG_PREFIX_CHARS, cur_prefix);
            wdata = {$urandom, $urandom};
            wdata[PLEN_W-1:0] = PLEN_W'(pl);
            write_reg(CFG_PREFIX_LENGTH, wdata);
            wdata = {$urandom, $urandom};
            wdata[NBYTES_W-1:0] = NBYTES_W'(nb);
            write_reg(CFG_ID_BYTE_COUNT, wdata);
            i_cfg_we <= 1'b0;
            settings_used++;

            rx_eager = ($urandom_range(0, 3) == 0);
            // backpressure: receiver holds off while the sender streams back to back
            if (phase == 3) begin
                hold_cycles = 80;
                burst_texts = 3;
            end

            phase_chars = 0;
            while (phase_chars < 150) begin
                r = $urandom_range(0, 99);
                if (phase == 5 && phase_chars == 0) kind = TK_HUGE;
                else if (r < 45) kind = TK_GOOD;
                else if (r < 55) kind = TK_NONCANON;
                else if (r < 63) kind = TK_BAD_PREFIX;
                else if (r < 70) kind = TK_SHORT;
                else if (r < 77) kind = TK_LONG;
                else if (r < 83) kind = TK_UPPER;
                else if (r < 90) kind = TK_BADCHAR;
                else if (r < 94) kind = TK_CUT_PREFIX;
                else kind = TK_NOISE;

                blen = (eff_nbytes * 8 + 4) / 5;
                lo = blen * 5 - eff_nbytes * 8;
                mask = (1 << lo) - 1;
                for (int i = 0; i < eff_plen; i++)
                    text_q.insert(text_q.size(), cur_prefix[8*i +: 8]);
                for (int i = 0; i < blen; i++) begin
                    v = $urandom_range(0, 31);
                    if (i == blen - 1) begin
                        v = v & ~mask;
                        if (kind == TK_NONCANON && lo > 0) v = v | $urandom_range(1, mask);
                    end
                    text_q.insert(text_q.size(), sym_char(v));
                end

                case (kind)
                    TK_BAD_PREFIX: begin
                        if (eff_plen > 0) begin
                            pos = $urandom_range(0, eff_plen - 1);
                            text_q[pos] = text_q[pos] ^ 8'($urandom_range(1, 255));
                        end
                    end
                    TK_SHORT: begin
                        k = $urandom_range(1, (blen - 1 < 3) ? blen - 1 : 3);
                        repeat (k) void'(text_q.pop_back());
                    end
                    TK_LONG: begin
                        repeat ($urandom_range(1, 6))
                            text_q.insert(text_q.size(), sym_char($urandom_range(0, 31)));
                    end
                    TK_UPPER: begin
                        pos = eff_plen + $urandom_range(0, blen - 1);
                        text_q[pos] = 8'("A" + $urandom_range(0, 25));
                    end
                    TK_BADCHAR: begin
                        pos = eff_plen + $urandom_range(0, blen - 1);
                        if ($urandom_range(0, 1) == 0) begin
                            c = near_miss[$urandom_range(0, 7)];
                        end else begin
                            do c = 8'($urandom_range(0, 255));
                            while ((c >= "a" && c <= "z") || (c >= "2" && c <= "7") ||
                                   (c >= "A" && c <= "Z"));
                        end
                        text_q[pos] = c;
                    end
                    TK_CUT_PREFIX: begin
                        if (eff_plen >= 2) begin
                            k = $urandom_range(1, eff_plen - 1);
                            while (text_q.size() > k) void'(text_q.pop_back());
                        end
                    end
                    TK_NOISE: begin
                        text_q.delete();
                        repeat ($urandom_range(1, 12))
                            text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                    end
                    TK_HUGE: begin
                        // long enough to saturate the character count
                        repeat (300)
                            text_q.insert(text_q.size(), sym_char($urandom_range(0, 31)));
                    end
                    default: ;
                endcase

                phase_chars += text_q.size();
                random_chars += text_q.size();
                send_text();
            end
            wait_idle();
        end

        rx_eager = 1'b0;
        wait_idle();
        repeat (6) @(posedge i_clk);

        $display("covered %0d texts, %0d characters over %0d register settings",
                 texts_sent, chars_sent, settings_used);
        $display({"checked %0d outputs: %0d bytes,",
                  " status ok/prefix/length/char/noncanon %0d/%0d/%0d/%0d/%0d"},
                 tracker.results_checked, tracker.bytes_checked, tracker.status_seen[0],
                 tracker.status_seen[1], tracker.status_seen[2], tracker.status_seen[3],
                 tracker.status_seen[4]);
        if (tracker.mismatches == 0 && tracker.expected_out.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
